[src/stg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stg_pkg - shared definitions for the sine tone generator
// Field widths, register indexes, codes and the unit status type.
// ----------------------------------------------------------------------------
package stg_pkg;

  // parameter defaults
  localparam int FS_HZ_DEF            = 48000;
  localparam int FADE_LEN_DEF         = 256;
  localparam int PHASE_BITS_DEF       = 32;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;

  // field and register widths
  localparam int AMP_W     = 15;
  localparam int HOLD_W    = 20;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 1;
  localparam int HZ_W      = 16;
  localparam int MS_W      = 16;
  localparam int SMP_W     = 16;
  localparam int FRAMES_W  = 22;
  localparam int SILENT_W  = 20;

  localparam int IN_DATA_W  = 32;  // tone_hz, duration_ms
  localparam int OUT_DATA_W = 40;  // left, right, amp_enable, zero pad

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_HOLD  = 1'd1;

  localparam logic [AMP_W-1:0]  AMP_RST  = 15'd19660;
  localparam logic [HOLD_W-1:0] HOLD_RST = 20'd19200;

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam int FULL_SCALE = 32767;
  localparam int MS_PER_S   = 1000;

  localparam logic [FRAMES_W-1:0] FRAMES_MAX = '1;
  localparam logic [SILENT_W-1:0] SILENT_MAX = '1;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;  // one-cycle pulse, result valid
  } stg_unit_sts_t;

endpackage
`default_nettype wire

[src/stg_sine_rom.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stg_sine_rom - quarter-wave sine table
// DEPTH+1 entries of 32767*sin(pi/2*k/DEPTH), built at elaboration; registered read.
// ----------------------------------------------------------------------------
module stg_sine_rom import stg_pkg::*; #(
  parameter int DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(SINE_TABLE_DEPTH_DEF + 1)
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    addr,
  output logic      [AMP_W-1:0] rd_data
);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // long division, elaboration only
  function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q30 Taylor series, six terms past x, rounded half up
  function automatic logic [AMP_W-1:0] sine_entry(input int k, input int depth);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] v;
    x    = cdiv(HALF_PI_Q30 * 64'(k), 64'(depth));
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = '0;
    term = ((term * x2) >> 30) / 6;   neg = neg + term;
    term = ((term * x2) >> 30) / 20;  pos = pos + term;
    term = ((term * x2) >> 30) / 42;  neg = neg + term;
    term = ((term * x2) >> 30) / 72;  pos = pos + term;
    term = ((term * x2) >> 30) / 110; neg = neg + term;
    term = ((term * x2) >> 30) / 156; pos = pos + term;
    s = (pos > neg) ? pos - neg : 64'd0;
    v = (s * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return AMP_W'(v);
  endfunction

  logic [AMP_W-1:0] tab [DEPTH+1];

  for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
    localparam logic [AMP_W-1:0] VAL = sine_entry(k, DEPTH);
    assign tab[k] = VAL;
  end

  always_ff @(posedge clk) begin
    rd_data <= tab[addr];
  end

endmodule
`default_nettype wire

[src/stg_serial_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stg_serial_mul - shift-add multiplier
// One multiplier bit per cycle, LSB first, then a done pulse.
// ----------------------------------------------------------------------------
module stg_serial_mul import stg_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [AW-1:0]     a,
  input  wire logic [BW-1:0]     b,
  output logic      [AW+BW-1:0]  p,
  output stg_unit_sts_t          sts
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0]    a_r;
  logic [AW+BW-1:0] p_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [AW:0]      sum;

  // high half plus multiplicand when the current multiplier bit is set
  assign sum = {1'b0, p_r[AW+BW-1:BW]} + (p_r[0] ? {1'b0, a_r} : {(AW+1){1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        p_r    <= {{AW{1'b0}}, b};
        cnt_r  <= CW'(BW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        p_r   <= {sum, p_r[BW-1:1]};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign p        = p_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
`default_nettype wire

[src/stg_serial_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stg_serial_div - restoring divider
// One quotient bit per cycle, MSB first, then a done pulse.
// ----------------------------------------------------------------------------
module stg_serial_div import stg_pkg::*; #(
  parameter int NW  = 48,
  parameter int DVW = 27
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [NW-1:0]  n,
  input  wire logic [DVW-1:0] d,
  output logic      [NW-1:0]  q,
  output stg_unit_sts_t       sts
);

  localparam int CW = $clog2(NW + 1);

  logic [DVW-1:0] d_r;
  logic [DVW-1:0] rem_r;
  logic [NW-1:0]  quo_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [DVW:0]   trial;
  logic [DVW:0]   diff;
  logic           ge;

  // remainder stays below the divisor, so trial < 2*d
  assign trial = {rem_r, quo_r[NW-1]};
  assign ge    = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        d_r    <= d;
        rem_r  <= '0;
        quo_r  <= n;
        cnt_r  <= CW'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
        quo_r <= {quo_r[NW-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign q        = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
`default_nettype wire

[src/sine_tone_generator_with_ramp_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sine_tone_generator_with_ramp_unit - DDS sine tone generator with fade-in
// Start-tone commands and sample ticks in, one stereo frame per tick out.
// ----------------------------------------------------------------------------
// A request on the input stream is either a start-tone command (tuser = 0)
// or a sample tick (tuser = 1). A start with nonzero tone_hz and duration_ms
// loads frames = FS_HZ*ms/1000 (saturated to 22 bits) and a phase step
// of hz*2^PHASE_BITS/FS_HZ, clears the phase and fade-in and turns the
// amplifier on; it gives no result, and a zero frequency or duration is
// dropped. Each tick gives one result: while frames remain, a sine sample
// from a quarter-wave table scaled by the amplitude register and a linear
// fade-in over FADE_LEN frames (truncated toward zero); afterwards
// silence, with amp_enable dropping once more than amp_hold_ticks silent
// ticks have passed. The sequencer uses the shift-add multiplier, MB
// bits wide (16 at defaults) with a PW-bit product (48 at defaults),
// which retires one multiplier bit per cycle and runs three times per
// tone frame, and the restoring divider, which retires one quotient bit
// per cycle. One request is worked at a time; the next is taken as soon
// as the previous result sits in the output register, even if the
// consumer has not yet taken it. Configuration writes take effect at
// once and belong in idle time.
// ----------------------------------------------------------------------------
module sine_tone_generator_with_ramp_unit import stg_pkg::*; #(
  parameter int FS_HZ            = FS_HZ_DEF,
  parameter int FADE_LEN         = FADE_LEN_DEF,
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] tone_hz, [31:16] duration_ms
  input  wire logic                  in_tuser,   // [0] operation
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [15:0] left_sample, [31:16] right_sample,
                                                 // [32] amp_enable, [39:33] zero
  output logic                       out_tuser,  // [0] playing
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  function automatic int cmax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int PB      = PHASE_BITS;
  localparam int SRW     = $clog2(FS_HZ + 1);
  localparam int RW      = $clog2(FADE_LEN + 1);               // ramp counter
  localparam int IW      = $clog2(4 * SINE_TABLE_DEPTH);       // full-wave table index
  localparam int OW      = $clog2(SINE_TABLE_DEPTH + 1);       // table address
  localparam int ENV_DIV = FULL_SCALE * FADE_LEN;
  // multiplier operands: phase, ms, table value, table*amplitude / scale factors
  localparam int MA      = cmax(PB, 2 * AMP_W);
  localparam int MB      = cmax(cmax(cmax(SRW, $clog2(4 * SINE_TABLE_DEPTH + 1)),
                                     cmax(AMP_W, RW)), HZ_W);
  localparam int PW      = MA + MB;                            // also the dividend width
  localparam int DVW     = cmax(cmax(SRW, $clog2(MS_PER_S + 1)), $clog2(ENV_DIV + 1));
  localparam int PAD_W   = OUT_DATA_W - 2 * SMP_W - 1;

  localparam logic [IW-1:0] Q1_BASE = IW'(SINE_TABLE_DEPTH);
  localparam logic [IW-1:0] Q2_BASE = IW'(2 * SINE_TABLE_DEPTH);
  localparam logic [IW-1:0] Q3_BASE = IW'(3 * SINE_TABLE_DEPTH);

  // --------------------------------------------------------------------------
  // Sequencer codes
  // --------------------------------------------------------------------------
  localparam logic [3:0] S_IDLE = 4'd0;  // take a request
  localparam logic [3:0] S_FMUL = 4'd1;  // ms * FS_HZ
  localparam logic [3:0] S_FDIV = 4'd2;  // / 1000 -> frame count
  localparam logic [3:0] S_PDIV = 4'd3;  // (hz << PB) / FS_HZ -> step
  localparam logic [3:0] S_IDX  = 4'd4;  // phase * 4*DEPTH -> table index
  localparam logic [3:0] S_ROM  = 4'd5;  // table read
  localparam logic [3:0] S_MAG1 = 4'd6;  // value * amplitude
  localparam logic [3:0] S_MAG2 = 4'd7;  // * ramp
  localparam logic [3:0] S_TDIV = 4'd8;  // / (32767 * FADE_LEN)
  localparam logic [3:0] S_OUT  = 4'd9;  // hand result to output register

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [3:0]          state_r, state_nxt;
  logic [AMP_W-1:0]    amp_r;
  logic [HOLD_W-1:0]   hold_r;
  logic [FRAMES_W-1:0] frames_r;
  logic [PB-1:0]       phase_r;
  logic [PB-1:0]       step_r;
  logic [RW-1:0]       ramp_r;
  logic                amp_on_r;
  logic [SILENT_W-1:0] silent_r;
  logic [HZ_W-1:0]     hz_r;
  logic [1:0]          quad_r;

  // pending result and output register
  logic [SMP_W-1:0]    res_smp_r;
  logic                res_play_r;
  logic                res_amp_r;
  logic                out_tvalid_r;
  logic [SMP_W-1:0]    out_smp_r;
  logic                out_play_r;
  logic                out_amp_r;

  // --------------------------------------------------------------------------
  // Arithmetic units
  // --------------------------------------------------------------------------
  logic            mul_start;
  logic [MA-1:0]   mul_a;
  logic [MB-1:0]   mul_b;
  logic [PW-1:0]   mul_p;
  stg_unit_sts_t   mul_sts;
  logic            div_start;
  logic [PW-1:0]   div_n;
  logic [DVW-1:0]  div_d;
  logic [PW-1:0]   div_q;
  stg_unit_sts_t   div_sts;
  logic [AMP_W-1:0] rom_q;
  logic [OW-1:0]   rom_addr;

  stg_serial_mul #(.AW(MA), .BW(MB)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .sts   (mul_sts)
  );

  stg_serial_div #(.NW(PW), .DVW(DVW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .q     (div_q),
    .sts   (div_sts)
  );

  // address comes straight from the index product, so the read lands in S_ROM
  stg_sine_rom #(.DEPTH(SINE_TABLE_DEPTH), .AW(OW)) u_rom (
    .clk     (clk),
    .addr    (rom_addr),
    .rd_data (rom_q)
  );

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic            in_acc;
  logic [HZ_W-1:0] in_hz;
  logic [MS_W-1:0] in_ms;
  logic            start_ok;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_hz     = in_tdata[HZ_W-1:0];
  assign in_ms     = in_tdata[HZ_W+MS_W-1:HZ_W];
  assign start_ok  = (in_hz != '0) && (in_ms != '0);

  // silent tick: hold counter and amplifier turn-off
  logic [SILENT_W-1:0] silent_inc;
  logic                hold_over;

  assign silent_inc = (silent_r < SILENT_MAX) ? silent_r + SILENT_W'(1) : silent_r;
  assign hold_over  = silent_inc > hold_r;

  // table index split into quadrant and offset; odd quadrants read mirrored
  logic [IW-1:0] idx;
  logic [1:0]    quad;
  logic [IW-1:0] q_base;
  logic [OW-1:0] offs;

  assign idx = IW'(mul_p >> PB);

  always_comb begin
    if (idx >= Q3_BASE) begin
      quad   = 2'd3;
      q_base = Q3_BASE;
    end else if (idx >= Q2_BASE) begin
      quad   = 2'd2;
      q_base = Q2_BASE;
    end else if (idx >= Q1_BASE) begin
      quad   = 2'd1;
      q_base = Q1_BASE;
    end else begin
      quad   = 2'd0;
      q_base = '0;
    end
  end

  assign offs     = OW'(idx - q_base);
  assign rom_addr = quad[0] ? OW'(SINE_TABLE_DEPTH) - offs : offs;

  // enveloped sample, negated in the lower half-wave (magnitude fits 15 bits)
  logic [SMP_W-1:0] mag;
  logic [SMP_W-1:0] tone_smp;

  assign mag      = SMP_W'(div_q);
  assign tone_smp = quad_r[1] ? (~mag + SMP_W'(1)) : mag;

  // --------------------------------------------------------------------------
  // Sequencer and unit operand selection
  // --------------------------------------------------------------------------
  logic out_load;

  assign out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_TICK) begin
            if (frames_r != '0) begin
              mul_start = 1'b1;
              mul_a     = MA'(phase_r);
              mul_b     = MB'(4 * SINE_TABLE_DEPTH);
              state_nxt = S_IDX;
            end else begin
              state_nxt = S_OUT;
            end
          end else if (start_ok) begin
            mul_start = 1'b1;
            mul_a     = MA'(in_ms);
            mul_b     = MB'(FS_HZ);
            state_nxt = S_FMUL;
          end
        end
      end
      S_FMUL: begin
        if (mul_sts.done) begin
          div_start = 1'b1;
          div_n     = mul_p;
          div_d     = DVW'(MS_PER_S);
          state_nxt = S_FDIV;
        end
      end
      S_FDIV: begin
        if (div_sts.done) begin
          div_start = 1'b1;
          div_n     = PW'(hz_r) << PB;
          div_d     = DVW'(FS_HZ);
          state_nxt = S_PDIV;
        end
      end
      S_PDIV: begin
        if (div_sts.done) state_nxt = S_IDLE;
      end
      S_IDX: begin
        if (mul_sts.done) state_nxt = S_ROM;
      end
      S_ROM: begin
        mul_start = 1'b1;
        mul_a     = MA'(rom_q);
        mul_b     = MB'(amp_r);
        state_nxt = S_MAG1;
      end
      S_MAG1: begin
        if (mul_sts.done) begin
          mul_start = 1'b1;
          mul_a     = MA'(mul_p);
          mul_b     = MB'(ramp_r);   // ramp saturates, so it is already min(ramp, FADE_LEN)
          state_nxt = S_MAG2;
        end
      end
      S_MAG2: begin
        if (mul_sts.done) begin
          div_start = 1'b1;
          div_n     = mul_p;
          div_d     = DVW'(ENV_DIV);
          state_nxt = S_TDIV;
        end
      end
      S_TDIV: begin
        if (div_sts.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // State and datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      amp_r        <= AMP_RST;
      hold_r       <= HOLD_RST;
      frames_r     <= '0;
      phase_r      <= '0;
      step_r       <= '0;
      ramp_r       <= '0;
      amp_on_r     <= 1'b0;
      silent_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_AMPLITUDE: amp_r  <= cfg_wdata[AMP_W-1:0];
          CFG_AMP_HOLD:  hold_r <= cfg_wdata[HOLD_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_smp_r    <= res_smp_r;
        out_play_r   <= res_play_r;
        out_amp_r    <= res_amp_r;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tuser == OP_TICK) begin
              if (frames_r == '0) begin
                // silence; count toward amplifier turn-off
                res_smp_r  <= '0;
                res_play_r <= 1'b0;
                res_amp_r  <= amp_on_r && !hold_over;
                if (amp_on_r) begin
                  if (hold_over) begin
                    amp_on_r <= 1'b0;
                    silent_r <= '0;
                  end else begin
                    silent_r <= silent_inc;
                  end
                end
              end
            end else if (start_ok) begin
              hz_r <= in_hz;
            end
          end
        end
        S_FDIV: begin
          if (div_sts.done) begin
            frames_r <= (div_q > PW'(FRAMES_MAX)) ? FRAMES_MAX : FRAMES_W'(div_q);
          end
        end
        S_PDIV: begin
          if (div_sts.done) begin
            step_r   <= div_q[PB-1:0];   // wraps at and above the sample rate
            phase_r  <= '0;
            ramp_r   <= '0;
            amp_on_r <= 1'b1;
            silent_r <= '0;
          end
        end
        S_IDX: begin
          if (mul_sts.done) begin
            quad_r <= quad;
          end
        end
        S_TDIV: begin
          if (div_sts.done) begin
            res_smp_r  <= tone_smp;
            res_play_r <= 1'b1;
            res_amp_r  <= amp_on_r;
            if (ramp_r < RW'(FADE_LEN)) ramp_r <= ramp_r + RW'(1);
            phase_r  <= phase_r + step_r;
            frames_r <= frames_r - FRAMES_W'(1);
            silent_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_amp_r, out_smp_r, out_smp_r};
  assign out_tuser  = out_play_r;

endmodule
`default_nettype wire

[src/stg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stg_checker - port-level assertions for the tone generator
// Watches the result stream; bound to the top level below.
// ----------------------------------------------------------------------------
module stg_checker import stg_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // both channels carry the same sample
  a_stereo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[SMP_W-1:0] == out_tdata[2*SMP_W-1:SMP_W])
    else $error("left and right differ");

  // a frame outside a tone is silent
  a_silence: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[2*SMP_W-1:0] == '0)
    else $error("nonzero sample while not playing");

  // a tone frame always has the amplifier on
  a_amp_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2*SMP_W])
    else $error("tone frame with amplifier off");

endmodule

bind sine_tone_generator_with_ramp_unit stg_checker u_stg_checker (.*);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking testbench for sine_tone_generator_with_ramp_unit
// Drives start-tone and sample-tick requests with random gaps, stalls the
// result stream at random, and checks every frame against a local predictor
// of the generator or a typed tour frame, over several amplitude and hold settings.
// ----------------------------------------------------------------------------
module tb_top;
  import stg_pkg::*;

  localparam int DEPTH = SINE_TABLE_DEPTH_DEF;
  localparam int RAMP  = FADE_LEN_DEF;
  localparam int PB    = PHASE_BITS_DEF;
  localparam longint unsigned RATE = FS_HZ_DEF;
  // pi/2 in Q30, seed of the quarter-wave series
  localparam bit [63:0] HALF_PI_Q30 = 64'd1686629713;
  // a start request may still be busy in the divider when the last frame is
  // out, so leave some margin
  localparam int SETTLE_CYCLES = 160;

  // one stereo frame as it leaves the block
  typedef struct packed {
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
    logic                    playing;
    logic                    amp_en;
  } frame_t;

  // one request of the directed tour; typed rows carry a hand-written frame
  typedef struct packed {
    logic                    op;
    logic [HZ_W-1:0]         hz;
    logic [MS_W-1:0]         ms;
    logic                    typed;
    logic signed [SMP_W-1:0] smp;
    logic                    playing;
    logic                    amp_en;
  } tour_row_t;

  // --------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // [15:0] tone_hz, [31:16] duration_ms
  logic                  in_tuser   = 1'b0;  // [0] operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // [15:0] left, [31:16] right, [32] amp_enable
  logic                  out_tuser;  // [0] playing
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  always #5 clk = ~clk;

  sine_tone_generator_with_ramp_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the generator's registers
  // --------------------------------------------------------------------------
  bit [15:0]         quarter_sine [0:DEPTH];
  bit [AMP_W-1:0]    amp_reg     = AMP_RST;
  bit [HOLD_W-1:0]   hold_reg    = HOLD_RST;
  bit [FRAMES_W-1:0] frames_left = '0;
  bit [PB-1:0]       phase_acc   = '0;
  bit [PB-1:0]       phase_step  = '0;
  int unsigned       ramp_cnt    = 0;
  bit                amp_on      = 1'b0;
  bit [SILENT_W-1:0] silent_cnt  = '0;

  frame_t      frames_due [$];   // frames owed by the block, oldest first
  int unsigned err_cnt    = 0;
  int unsigned stall_left = 0;
  bit          calm       = 1'b0; // no gaps or stalls while set

  // Directed tour: reset state, ignored starts, quadrant edges, extremes.
  tour_row_t tour [25] = '{
    // silence straight after reset, amplifier off
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 16'sd0, 1'b0, 1'b0},
    // zero frequency or zero duration: start is dropped
    '{OP_START, 16'd0,     16'd100,   1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_START, 16'd1000,  16'd0,     1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_START, 16'd0,     16'd0,     1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 16'sd0, 1'b0, 1'b0},
    // quarter-rate tone: phase lands on every quadrant boundary
    '{OP_START, 16'd12000, 16'd1,     1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 16'sd0, 1'b1, 1'b1},  // ramp still zero
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 16'sd0, 1'b0, 1'b0},
    // restart while playing, top frequency aliases, longest duration
    '{OP_START, 16'hFFFF,  16'hFFFF,  1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 16'sd0, 1'b1, 1'b1},
    '{OP_TICK,  16'hFFFF,  16'hFFFF,  1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 16'sd0, 1'b0, 1'b0},
    // half-rate tone
    '{OP_START, 16'd24000, 16'd1,     1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 16'sd0, 1'b1, 1'b1},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 16'sd0, 1'b0, 1'b0},
    // tone at the sample rate: step wraps to zero, sine stays at zero
    '{OP_START, 16'd48000, 16'd1,     1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 16'sd0, 1'b1, 1'b1},
    '{OP_TICK,  16'd0,     16'd0,     1'b1, 16'sd0, 1'b1, 1'b1},
    // lowest frequency
    '{OP_START, 16'd1,     16'd1,     1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 16'sd0, 1'b0, 1'b0},
    '{OP_TICK,  16'd0,     16'd0,     1'b0, 16'sd0, 1'b0, 1'b0}
  };

  // Quarter-wave table: Taylor series of sin in Q30, six terms, scaled to
  // 32767 with round half up.
  function automatic void build_quarter_sine();
    bit [63:0] x, x2, term, pos, neg, s, v;
    int k, n;
    for (k = 0; k <= DEPTH; k++) begin
      x    = HALF_PI_Q30 * k / DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 0;
      for (n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) neg += term;
        else pos += term;
      end
      s = (pos > neg) ? pos - neg : 64'd0;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      quarter_sine[k] = (v > 64'd32767) ? 16'd32767 : v[15:0];
    end
  endfunction

  // Advance the predictor by one request; returns 1 when a frame is due.
  function automatic bit predict_frame(logic op, logic [HZ_W-1:0] hz,
                                       logic [MS_W-1:0] ms, output frame_t fr);
    bit [63:0] span, idx, mag, r, m;
    bit [1:0]  quad;
    int        off;
    fr = '0;
    if (op == OP_START) begin
      if (hz != 0 && ms != 0) begin
        span        = RATE * ms / MS_PER_S;
        frames_left = (span > FRAMES_MAX) ? FRAMES_MAX : span[FRAMES_W-1:0];
        span        = (64'(hz) << PB) / RATE;
        phase_step  = span[PB-1:0];
        phase_acc   = '0;
        ramp_cnt    = 0;
        amp_on      = 1'b1;
        silent_cnt  = '0;
      end
      return 1'b0;
    end
    if (frames_left != 0) begin
      idx  = (64'(phase_acc) * (4 * DEPTH)) >> PB;
      span = idx / DEPTH;
      quad = span[1:0];
      off  = int'(idx % DEPTH);
      mag  = 64'(quad[0] ? quarter_sine[DEPTH - off] : quarter_sine[off]);
      r    = 64'((ramp_cnt < RAMP) ? ramp_cnt : RAMP);
      m    = mag * amp_reg * r / (64'(FULL_SCALE) * RAMP);
      if (quad[1]) m = 64'd0 - m;
      if (ramp_cnt < RAMP) ramp_cnt++;
      phase_acc   = phase_acc + phase_step;
      frames_left = frames_left - 1'b1;
      silent_cnt  = '0;
      fr.left     = m[SMP_W-1:0];
      fr.right    = m[SMP_W-1:0];
      fr.playing  = 1'b1;
      fr.amp_en   = amp_on;
      return 1'b1;
    end
    // silence; the hold only runs while the amplifier is on
    if (amp_on) begin
      if (silent_cnt != SILENT_MAX) silent_cnt++;
      if (silent_cnt > hold_reg) begin
        amp_on     = 1'b0;
        silent_cnt = '0;
      end
    end
    fr.amp_en = amp_on;
    return 1'b1;
  endfunction

  function automatic int unsigned pause_len();
    if (calm) return 0;
    return $urandom_range(0, 8);
  endfunction

  function automatic tour_row_t req(logic op, logic [HZ_W-1:0] hz, logic [MS_W-1:0] ms);
    tour_row_t row;
    row    = '0;
    row.op = op;
    row.hz = hz;
    row.ms = ms;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: present one request after a random gap, hold it until taken.
  // Called on a clock edge; valid is only lowered when a gap follows, so a
  // back-to-back request never sees two assignments in one step.
  // --------------------------------------------------------------------------
  task automatic send(tour_row_t row);
    frame_t      fr;
    int unsigned gap;
    gap = pause_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.op;
    in_tdata  <= {row.ms, row.hz};
    do @(posedge clk); while (!in_tready);
    if (predict_frame(row.op, row.hz, row.ms, fr)) begin
      if (row.typed) fr = '{row.smp, row.smp, row.playing, row.amp_en};
      frames_due.push_back(fr);
    end
  endtask

  // Stop sending, wait for every owed frame, then let a start finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_AMPLITUDE) amp_reg = val[AMP_W-1:0];
    else hold_reg = val[HOLD_W-1:0];
  endtask

  // Random traffic: mostly a start followed by a run of ticks that either
  // cuts the tone short (restart) or runs past its end into silence; the
  // rest is single requests with any field value, zeros included.
  task automatic run_tones(int unsigned budget, bit long_first);
    int unsigned     sent, ticks, frames, i;
    logic [HZ_W-1:0] hz;
    logic [MS_W-1:0] ms;
    bit              first;
    sent  = 0;
    first = long_first;
    while (sent < budget) begin
      calm = ($urandom_range(0, 3) == 0);
      if (first || $urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 3))
          0:       hz = HZ_W'($urandom_range(1, 1000));
          1:       hz = HZ_W'($urandom_range(1000, 20000));
          2:       hz = HZ_W'($urandom_range(1, 65535));
          default: hz = 16'd12000 << $urandom_range(0, 2);
        endcase
        // a long tone lets the fade-in reach its ceiling
        ms     = first ? 16'd6 : 16'($urandom_range(1, 2));
        frames = FS_HZ_DEF * ms / MS_PER_S;
        ticks  = first ? frames + 4 : $urandom_range(frames / 2, frames + 8);
        send(req(OP_START, hz, ms));
        for (i = 0; i < ticks; i++) begin
          hz = HZ_W'($urandom);
          ms = MS_W'($urandom);
          send(req(OP_TICK, hz, ms));
        end
        sent += ticks + 1;
        first = 1'b0;
      end else begin
        hz = HZ_W'($urandom);
        ms = MS_W'($urandom);
        if ($urandom_range(0, 3) == 0) hz = '0;
        if ($urandom_range(0, 3) == 0) ms = '0;
        send(req($urandom_range(0, 1) ? OP_TICK : OP_START, hz, ms));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: check each frame taken, then stall a random number of cycles
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_t      got, want;
    int unsigned hold;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tready && out_tvalid) begin
      got.left    = out_tdata[15:0];
      got.right   = out_tdata[31:16];
      got.amp_en  = out_tdata[32];
      got.playing = out_tuser;
      if (frames_due.size() == 0) begin
        $display("%0t: frame with none owed: left %0d right %0d playing %0b amp %0b",
                 $time, got.left, got.right, got.playing, got.amp_en);
        err_cnt++;
      end else begin
        want = frames_due.pop_front();
        if (got !== want) begin
          $display("%0t: frame mismatch: expected left %0d right %0d playing %0b amp %0b",
                   $time, want.left, want.right, want.playing, want.amp_en);
          $display("%0t:                 actual   left %0d right %0d playing %0b amp %0b",
                   $time, got.left, got.right, got.playing, got.amp_en);
          err_cnt++;
        end
      end
      hold = pause_len();
      if (hold != 0) begin
        out_tready <= 1'b0;
        stall_left <= hold - 1;
      end
    end else if (!out_tready) begin
      if (stall_left == 0) out_tready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int i;
    build_quarter_sine();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed tour at reset settings
    for (i = 0; i < $size(tour); i++) send(tour[i]);
    settle();

    // full amplitude, amplifier off on the first silent tick; long tone here
    write_reg(CFG_AMPLITUDE, CFG_W'(32767));
    write_reg(CFG_AMP_HOLD, CFG_W'(0));
    run_tones(250, 1'b1);
    settle();

    // muted tone, hold that never expires
    write_reg(CFG_AMPLITUDE, CFG_W'(0));
    write_reg(CFG_AMP_HOLD, CFG_W'(20'hFFFFF));
    run_tones(100, 1'b0);
    settle();

    // random amplitude, short holds so the amplifier toggles often
    write_reg(CFG_AMPLITUDE, CFG_W'($urandom_range(1, 32766)));
    write_reg(CFG_AMP_HOLD, CFG_W'($urandom_range(0, 30)));
    run_tones(100, 1'b0);
    settle();

    // smallest nonzero amplitude, hold anywhere in its range
    write_reg(CFG_AMPLITUDE, CFG_W'(1));
    write_reg(CFG_AMP_HOLD, CFG_W'($urandom_range(0, 20'hFFFFF)));
    run_tones(100, 1'b0);
    settle();

    if (err_cnt == 0 && frames_due.size() == 0) begin
      $display("sine_tone_generator_with_ramp_unit test passed");
    end else begin
      $display("sine_tone_generator_with_ramp_unit test failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs about a tenth of this.
  initial begin
    #(64'd10_000_000);
    $display("sine_tone_generator_with_ramp_unit test failed");
    $finish;
  end

endmodule
